// File: hw/rtl/mcft_pkg.sv
// shared constants, types and crc function for the motor command frame translator
// no dependencies
package mcft_pkg;

    localparam int ID_W  = 4;
    localparam int IDX_W = 3;

    typedef logic [ID_W-1:0]  mcft_id_t;
    typedef logic [IDX_W-1:0] mcft_idx_t;
    typedef logic [7:0]       mcft_byte_t;

    localparam mcft_byte_t MF_START   = 8'h12;
    localparam mcft_byte_t MF_END     = 8'h13;
    localparam mcft_byte_t MF_CONST   = 8'h01;
    localparam mcft_byte_t MF_POLY    = 8'hD5;
    localparam mcft_byte_t MAG_ESCAPE = 8'd18;
    localparam mcft_byte_t MAG_SUBST  = 8'd17;
    localparam mcft_id_t   MOTOR0_ID  = 4'd2;

    // byte slots of one motor frame
    localparam mcft_idx_t FB_START = 3'd0;
    localparam mcft_idx_t FB_ID    = 3'd1;
    localparam mcft_idx_t FB_CONST = 3'd2;
    localparam mcft_idx_t FB_DIR   = 3'd3;
    localparam mcft_idx_t FB_MAG   = 3'd4;
    localparam mcft_idx_t FB_CRC   = 3'd5;
    localparam mcft_idx_t FB_END   = 3'd6;

    // reflected crc-8, one data byte, lsb first
    function automatic mcft_byte_t crc8_byte(input mcft_byte_t crc_in, input mcft_byte_t data);
        mcft_byte_t c;
        mcft_byte_t d;
        logic       mix;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++) begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix) begin
                c = c ^ MF_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/mcft_frame_byte.sv
// motor frame byte generator: field decode, crc and byte select for one slot
// depends on mcft_pkg
module mcft_frame_byte (
    input  mcft_pkg::mcft_id_t   motor_id,
    input  mcft_pkg::mcft_byte_t cmd_byte,
    input  mcft_pkg::mcft_idx_t  slot,
    output mcft_pkg::mcft_byte_t tx_byte,
    output logic                 frame_end
);

    mcft_pkg::mcft_byte_t id_byte;
    mcft_pkg::mcft_byte_t dir_byte;
    mcft_pkg::mcft_byte_t mag_raw;
    mcft_pkg::mcft_byte_t mag_byte;
    mcft_pkg::mcft_byte_t crc_byte;

    assign id_byte  = 8'(motor_id);
    assign dir_byte = {7'd0, ~cmd_byte[7]};
    assign mag_raw  = {cmd_byte[6:0], 1'b0};
    assign mag_byte = (mag_raw == mcft_pkg::MAG_ESCAPE) ? mcft_pkg::MAG_SUBST : mag_raw;

    assign crc_byte = mcft_pkg::crc8_byte(
                          mcft_pkg::crc8_byte(
                              mcft_pkg::crc8_byte(
                                  mcft_pkg::crc8_byte(8'd0, id_byte),
                                  mcft_pkg::MF_CONST),
                              dir_byte),
                          mag_byte);

    always_comb begin
        unique case (slot)
            mcft_pkg::FB_START: tx_byte = mcft_pkg::MF_START;
            mcft_pkg::FB_ID:    tx_byte = id_byte;
            mcft_pkg::FB_CONST: tx_byte = mcft_pkg::MF_CONST;
            mcft_pkg::FB_DIR:   tx_byte = dir_byte;
            mcft_pkg::FB_MAG:   tx_byte = mag_byte;
            mcft_pkg::FB_CRC:   tx_byte = crc_byte;
            mcft_pkg::FB_END:   tx_byte = mcft_pkg::MF_END;
            default:            tx_byte = mcft_pkg::MF_END;
        endcase
    end

    assign frame_end = (slot == mcft_pkg::FB_END);

endmodule

// File: hw/rtl/motor_command_frame_translator_top.sv
// top level of the motor command frame translator: position counter, frame register,
// byte serializer and output register; depends on mcft_pkg and mcft_frame_byte
//
// channel  | ports                              | dir
// s        | s_valid s_ready s_rx_byte          | in, upstream command bytes
// m        | m_valid m_ready m_tx_byte m_frame_end | out, motor frame bytes
//
// a byte at positions 1..MOTOR_COUNT yields seven output items, one per cycle unless m_ready stalls,
// so a new such byte waits until the output serializer has sent the previous frame
// other positions are always ready, even while a frame drains
// the next motor byte is taken in the cycle the last byte of the previous frame moves out
// synchronous active-low reset clears the position, frame and output valid state
module motor_command_frame_translator_top #(
    parameter int UPSTREAM_FRAME_LEN = 16,
    parameter int MOTOR_COUNT        = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_frame_end
);

    localparam int POS_W = $clog2(UPSTREAM_FRAME_LEN);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 frame_valid_reg, frame_valid_next;
    mcft_pkg::mcft_idx_t  idx_reg, idx_next;
    mcft_pkg::mcft_id_t   id_reg;
    mcft_pkg::mcft_byte_t data_reg;
    logic                 m_valid_reg, m_valid_next;
    mcft_pkg::mcft_byte_t m_tx_byte_reg;
    logic                 m_frame_end_reg;

    logic                 in_motor;
    logic                 idx_last;
    logic                 out_load;
    logic                 slot_free;
    logic                 s_acc;
    logic                 take;
    mcft_pkg::mcft_id_t   id_in;
    mcft_pkg::mcft_byte_t gen_byte;
    logic                 gen_end;

    assign in_motor  = (pos_reg != '0) && (8'(pos_reg) <= 8'(MOTOR_COUNT));
    assign idx_last  = (idx_reg == mcft_pkg::FB_END);
    assign out_load  = frame_valid_reg && (!m_valid_reg || m_ready);
    assign slot_free = !frame_valid_reg || (out_load && idx_last);
    assign s_ready   = !in_motor || slot_free;
    assign s_acc     = s_valid && s_ready;
    assign take      = s_acc && in_motor;
    assign id_in     = (pos_reg == POS_W'(1)) ? mcft_pkg::MOTOR0_ID
                                              : mcft_pkg::mcft_id_t'(pos_reg);

    always_comb begin
        pos_next = pos_reg;
        if (s_acc) begin
            pos_next = (pos_reg == POS_W'(UPSTREAM_FRAME_LEN - 1)) ? '0
                                                                  : POS_W'(pos_reg + 1'b1);
        end
    end

    always_comb begin
        frame_valid_next = frame_valid_reg;
        idx_next         = idx_reg;
        if (out_load) begin
            idx_next = mcft_pkg::mcft_idx_t'(idx_reg + 1'b1);
            if (idx_last) begin
                frame_valid_next = 1'b0;
            end
        end
        if (take) begin
            frame_valid_next = 1'b1;
            idx_next         = mcft_pkg::FB_START;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    mcft_frame_byte u_frame_byte (
        .motor_id  (id_reg),
        .cmd_byte  (data_reg),
        .slot      (idx_reg),
        .tx_byte   (gen_byte),
        .frame_end (gen_end)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            frame_valid_reg <= 1'b0;
            idx_reg         <= mcft_pkg::FB_START;
            m_valid_reg     <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            frame_valid_reg <= frame_valid_next;
            idx_reg         <= idx_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            id_reg   <= id_in;
            data_reg <= s_rx_byte;
        end
        if (out_load) begin
            m_tx_byte_reg   <= gen_byte;
            m_frame_end_reg <= gen_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tx_byte   = m_tx_byte_reg;
    assign m_frame_end = m_frame_end_reg;

`ifndef SYNTHESIS
    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_frame_end_reg |-> m_tx_byte_reg == mcft_pkg::MF_END)
        else $error("frame end flag without end marker");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_valid_reg |-> idx_reg <= mcft_pkg::FB_END)
        else $error("frame slot index out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !frame_valid_reg || (out_load && idx_last))
        else $error("motor item taken over a frame still draining");

    a_start_first: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && idx_reg == mcft_pkg::FB_START |=> m_tx_byte_reg == mcft_pkg::MF_START)
        else $error("frame does not open with start marker");

    a_take_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> frame_valid_reg && idx_reg == mcft_pkg::FB_START)
        else $error("new frame not started at first slot");
`endif

endmodule
